[src/refcounted_lru_byte_budget_cache_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the refcounted LRU tag manager
// Concurrent checks on the core clock, masked while in reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_LRU_BYTE_BUDGET_CACHE_ASSERT_SVH
`define REFCOUNTED_LRU_BYTE_BUDGET_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/rlc_pkg.sv]
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and codes of the refcounted LRU tag manager.
// ----------------------------------------------------------------------------
package rlc_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_LOOKUP    = 3'd1,
        ACT_CONTAINS  = 3'd2,
        ACT_RELEASE   = 3'd3,
        ACT_DEL_KEY   = 3'd4,
        ACT_DEL_FRAME = 3'd5,
        ACT_CLEAR     = 3'd6,
        ACT_PURGE     = 3'd7
    } rlc_action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_REL = 2'd3
    } rlc_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_COMPACT,
        S_APPEND,
        S_FINISH
    } rlc_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_COMPACT,
        CELL_LOAD
    } rlc_cell_op_t;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] frame;
        logic [31:0] nbytes;
        logic [15:0] refs;
    } rlc_data_t;

    localparam int unsigned TOTAL_W  = 38;
    localparam int unsigned BUDGET_W = 37;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 37'd1073741824;
    localparam logic [15:0]         REFS_MAX     = 16'hFFFF;
    localparam logic                REG_BUDGET   = 1'b0;

endpackage

[src/rlc_req_if.sv]
// ----------------------------------------------------------------------------
// rlc_req_if
// Request channel: one action beat with its operands.
// ----------------------------------------------------------------------------
interface rlc_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [15:0]        key_id;
    logic signed [31:0] frame_number;
    logic [31:0]        entry_bytes;
    logic [5:0]         slot_handle;

    modport source (output valid, action, key_id, frame_number, entry_bytes, slot_handle,
                    input ready);
    modport sink   (input valid, action, key_id, frame_number, entry_bytes, slot_handle,
                    output ready);
endinterface

[src/rlc_rsp_if.sv]
// ----------------------------------------------------------------------------
// rlc_rsp_if
// Response channel: one result beat per action.
// ----------------------------------------------------------------------------
interface rlc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [5:0]  slot_out;
    logic [37:0] total_bytes;
    logic [6:0]  entries_used;
    logic [6:0]  evicted_count;

    modport source (output valid, status, hit, slot_out, total_bytes, entries_used,
                    evicted_count, input ready);
    modport sink   (input valid, status, hit, slot_out, total_bytes, entries_used,
                    evicted_count, output ready);
endinterface

[src/rlc_cell.sv]
// ----------------------------------------------------------------------------
// rlc_cell
// One position of the recency chain: holds an entry, shifts from its neighbor.
// ----------------------------------------------------------------------------
module rlc_cell #(
    parameter int unsigned SW = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlc_pkg::rlc_cell_op_t op,
    input  logic                 ld_en,
    input  logic [SW-1:0]        ld_slot,
    input  rlc_pkg::rlc_data_t   ld_data,
    input  logic                 nxt_valid,
    input  logic [SW-1:0]        nxt_slot,
    input  rlc_pkg::rlc_data_t   nxt_data,
    input  logic                 hole_in,
    output logic                 hole_out,
    output logic                 valid,
    output logic [SW-1:0]        slot,
    output rlc_pkg::rlc_data_t   data
);
    import rlc_pkg::*;

    logic          valid_reg, valid_next;
    logic [SW-1:0] slot_reg, slot_next;
    rlc_data_t     data_reg, data_next;

    // a hole at or below this position pulls everything above down by one
    assign hole_out = hole_in | ~valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        data_next  = data_reg;
        case (op)
            CELL_ROTATE:
            begin
                valid_next = nxt_valid;
                slot_next  = nxt_slot;
                data_next  = nxt_data;
            end
            CELL_COMPACT:
            begin
                if (hole_out)
                begin
                    valid_next = nxt_valid;
                    slot_next  = nxt_slot;
                    data_next  = nxt_data;
                end
            end
            CELL_LOAD:
            begin
                if (ld_en)
                begin
                    valid_next = 1'b1;
                    slot_next  = ld_slot;
                    data_next  = ld_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign data  = data_reg;
endmodule

[src/rlc_chain.sv]
// ----------------------------------------------------------------------------
// rlc_chain
// Row of cells in recency order, oldest at position 0 (the head).
// ----------------------------------------------------------------------------
module rlc_chain #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned SW      = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlc_pkg::rlc_cell_op_t op,
    input  logic [SW-1:0]        ld_idx,
    input  logic [SW-1:0]        ld_slot,
    input  rlc_pkg::rlc_data_t   ld_data,
    input  logic                 tail_valid,
    input  logic [SW-1:0]        tail_slot,
    input  rlc_pkg::rlc_data_t   tail_data,
    output logic                 head_valid,
    output logic [SW-1:0]        head_slot,
    output rlc_pkg::rlc_data_t   head_data
);
    import rlc_pkg::*;

    logic          c_valid [ENTRIES];
    logic [SW-1:0] c_slot  [ENTRIES];
    rlc_data_t     c_data  [ENTRIES];
    logic          hole    [ENTRIES+1];

    assign hole[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic          n_valid;
        logic [SW-1:0] n_slot;
        rlc_data_t     n_data;

        if (i == ENTRIES - 1)
        begin : g_tail
            assign n_valid = tail_valid;
            assign n_slot  = tail_slot;
            assign n_data  = tail_data;
        end
        else
        begin : g_mid
            assign n_valid = c_valid[i+1];
            assign n_slot  = c_slot[i+1];
            assign n_data  = c_data[i+1];
        end

        rlc_cell #(.SW(SW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .ld_en     (ld_idx == SW'(i)),
            .ld_slot   (ld_slot),
            .ld_data   (ld_data),
            .nxt_valid (n_valid),
            .nxt_slot  (n_slot),
            .nxt_data  (n_data),
            .hole_in   (hole[i]),
            .hole_out  (hole[i+1]),
            .valid     (c_valid[i]),
            .slot      (c_slot[i]),
            .data      (c_data[i])
        );
    end

    assign head_valid = c_valid[0];
    assign head_slot  = c_slot[0];
    assign head_data  = c_data[0];
endmodule

[src/refcounted_lru_byte_budget_cache.sv]
// ----------------------------------------------------------------------------
// refcounted_lru_byte_budget_cache
// Tag manager for a frame cache: refcounted entries kept in LRU order under
// a byte budget, held in a rotating chain of cells.
// ----------------------------------------------------------------------------
// channel  dir  protocol       beat
// req      in   valid/ready    action, key_id, frame_number, entry_bytes, slot_handle
// rsp      out  valid/ready    status, hit, slot_out, total_bytes, entries_used,
//                              evicted_count
// apb      in   psel/penable   byte_budget at address 0 (64-bit data)
//
// One action at a time. The chain rotates once through all ENTRIES cells
// (the head is examined each cycle), then closes up once per removed entry
// (a lookup hit counts as one removed), appends, and hands the result to
// the response register in the finish state; the next request is taken
// only after the block has gone back to idle.
// An insert that goes over budget runs a second pass for the purge.
// Reset empties the table at once; no clearing pass.
// A stalled response holds the block in its final state until taken.
// ----------------------------------------------------------------------------
`include "refcounted_lru_byte_budget_cache_assert.svh"

module refcounted_lru_byte_budget_cache #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    rlc_req_if.sink     req,
    rlc_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rlc_pkg::*;

    localparam int unsigned SW   = $clog2(ENTRIES);
    localparam int unsigned UW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (SW > 6) ? SW : 6;
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

    rlc_state_t state_reg, state_next;

    logic [BUDGET_W-1:0] budget_reg;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [ENTRIES-1:0]  smap_reg, smap_next;

    rlc_action_t act_reg;
    logic [15:0] key_reg;
    logic [31:0] frame_reg;
    logic [31:0] bytes_reg;
    logic [5:0]  handle_reg;

    logic          purge_reg, purge_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [UW-1:0] rem_reg, rem_next;
    logic [UW-1:0] evict_reg, evict_next;
    logic          found_reg, found_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    rlc_data_t     hold_reg, hold_next;
    logic          free_ok_reg, free_ok_next;
    logic [SW-1:0] free_reg, free_next;

    logic        rsp_valid_reg;
    rlc_status_t status_reg, status_next;
    logic        hit_reg, hit_next;
    logic [5:0]  rslot_reg, rslot_next;

    rlc_cell_op_t  op;
    logic [SW-1:0] ld_idx, ld_slot;
    rlc_data_t     ld_data;
    logic          tail_valid;
    rlc_data_t     tail_data;
    logic          head_valid;
    logic [SW-1:0] head_slot;
    rlc_data_t     head_data;

    rlc_action_t       eff_act;
    logic              key_match, sel_match, drop;
    logic [TOTAL_W:0]  ins_sum;
    logic [TOTAL_W-1:0] ins_total;
    logic              ins_ok, over_after_ins;

    rlc_chain #(.ENTRIES(ENTRIES), .SW(SW)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .ld_idx     (ld_idx),
        .ld_slot    (ld_slot),
        .ld_data    (ld_data),
        .tail_valid (tail_valid),
        .tail_slot  (head_slot),
        .tail_data  (tail_data),
        .head_valid (head_valid),
        .head_slot  (head_slot),
        .head_data  (head_data)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_BUDGET) ? 64'(budget_reg) : 64'd0;

    assign req.ready = (state_reg == S_IDLE);

    assign eff_act   = purge_reg ? ACT_PURGE : act_reg;
    assign key_match = head_valid && (key_reg != 16'd0) && (head_data.key == key_reg);
    assign sel_match = key_match && (head_data.frame == frame_reg);

    assign ins_sum        = {1'b0, total_reg} + (TOTAL_W+1)'(bytes_reg);
    assign ins_total      = ins_sum[TOTAL_W] ? TOTAL_MAX : ins_sum[TOTAL_W-1:0];
    assign ins_ok         = free_ok_reg && (used_reg < UW'(ENTRIES));
    assign over_after_ins = ins_total > TOTAL_W'(budget_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (req.valid) state_next = S_WALK;
            S_WALK:    if (cnt_reg == LAST) state_next = S_COMPACT;
            S_COMPACT: if (rem_reg == '0) state_next = S_APPEND;
            S_APPEND:
            begin
                if (!purge_reg && act_reg == ACT_INSERT && ins_ok && over_after_ins)
                    state_next = S_WALK;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:  if (!rsp_valid_reg || rsp.ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op           = CELL_HOLD;
        ld_idx       = '0;
        ld_slot      = free_reg;
        ld_data      = '{key: key_reg, frame: frame_reg, nbytes: bytes_reg, refs: 16'd1};
        tail_valid   = head_valid;
        tail_data    = head_data;
        drop         = 1'b0;
        total_next   = total_reg;
        used_next    = used_reg;
        smap_next    = smap_reg;
        purge_next   = purge_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        evict_next   = evict_reg;
        found_next   = found_reg;
        fslot_next   = fslot_reg;
        hold_next    = hold_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        status_next  = status_reg;
        hit_next     = hit_reg;
        rslot_next   = rslot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                purge_next   = 1'b0;
                cnt_next     = '0;
                rem_next     = '0;
                evict_next   = '0;
                found_next   = 1'b0;
                free_ok_next = 1'b0;
            end
            S_WALK:
            begin
                op       = CELL_ROTATE;
                cnt_next = cnt_reg + SW'(1);
                case (eff_act)
                    ACT_INSERT:
                    begin
                        if (!free_ok_reg && !smap_reg[cnt_reg])
                        begin
                            free_ok_next = 1'b1;
                            free_next    = cnt_reg;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (sel_match && !found_reg)
                        begin
                            // pull the entry out; it goes back in at the young end
                            found_next = 1'b1;
                            fslot_next = head_slot;
                            hold_next  = head_data;
                            if (head_data.refs != REFS_MAX)
                                hold_next.refs = head_data.refs + 16'd1;
                            tail_valid = 1'b0;
                            rem_next   = rem_reg + UW'(1);
                        end
                    end
                    ACT_CONTAINS:
                    begin
                        if (sel_match && !found_reg)
                        begin
                            found_next = 1'b1;
                            fslot_next = head_slot;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (head_valid && CMPW'(head_slot) == CMPW'(handle_reg) &&
                            head_data.refs != 16'd0)
                        begin
                            found_next     = 1'b1;
                            tail_data.refs = head_data.refs - 16'd1;
                        end
                    end
                    ACT_DEL_KEY, ACT_DEL_FRAME:
                    begin
                        if (key_match && (act_reg == ACT_DEL_KEY || sel_match))
                        begin
                            if (head_data.refs == 16'd0)
                                drop = 1'b1;
                            else
                                tail_data.key = 16'd0;
                        end
                    end
                    ACT_CLEAR:
                        drop = head_valid && (head_data.refs == 16'd0);
                    ACT_PURGE:
                        drop = head_valid && (head_data.refs == 16'd0) &&
                               (total_reg > TOTAL_W'(budget_reg));
                    default:
                    begin
                    end
                endcase
                if (drop)
                begin
                    tail_valid           = 1'b0;
                    total_next           = (total_reg >= TOTAL_W'(head_data.nbytes)) ?
                                           total_reg - TOTAL_W'(head_data.nbytes) : '0;
                    used_next            = used_reg - UW'(1);
                    smap_next[head_slot] = 1'b0;
                    rem_next             = rem_reg + UW'(1);
                    evict_next           = evict_reg + UW'(1);
                end
            end
            S_COMPACT:
            begin
                if (rem_reg != '0)
                begin
                    // the top cell fills with an empty entry while the row closes up
                    op         = CELL_COMPACT;
                    tail_valid = 1'b0;
                    rem_next   = rem_reg - UW'(1);
                end
            end
            S_APPEND:
            begin
                status_next = ST_OK;
                hit_next    = 1'b0;
                rslot_next  = 6'd0;
                if (purge_reg)
                begin
                    purge_next = 1'b0;
                    rslot_next = 6'(free_reg);
                end
                else
                begin
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                op                  = CELL_LOAD;
                                ld_idx              = SW'(used_reg);
                                smap_next[free_reg] = 1'b1;
                                used_next           = used_reg + UW'(1);
                                total_next          = ins_total;
                                rslot_next          = 6'(free_reg);
                                if (over_after_ins)
                                begin
                                    purge_next = 1'b1;
                                    cnt_next   = '0;
                                    rem_next   = '0;
                                end
                            end
                            else
                                status_next = ST_FULL;
                        end
                        ACT_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                op         = CELL_LOAD;
                                ld_idx     = SW'(used_reg - UW'(1));
                                ld_slot    = fslot_reg;
                                ld_data    = hold_reg;
                                hit_next   = 1'b1;
                                rslot_next = 6'(fslot_reg);
                            end
                            else
                                status_next = ST_MISS;
                        end
                        ACT_CONTAINS:
                        begin
                            if (found_reg)
                            begin
                                hit_next   = 1'b1;
                                rslot_next = 6'(fslot_reg);
                            end
                            else
                                status_next = ST_MISS;
                        end
                        ACT_RELEASE:
                        begin
                            rslot_next = handle_reg;
                            if (!found_reg)
                                status_next = ST_BAD_REL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            budget_reg    <= BUDGET_RESET;
            total_reg     <= '0;
            used_reg      <= '0;
            smap_reg      <= '0;
            purge_reg     <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            used_reg    <= used_next;
            smap_reg    <= smap_next;
            purge_reg   <= purge_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            found_reg   <= found_next;
            free_ok_reg <= free_ok_next;
            if (psel && penable && pwrite && paddr[3] == REG_BUDGET)
                budget_reg <= pwdata[BUDGET_W-1:0];
            if (state_reg == S_FINISH && (!rsp_valid_reg || rsp.ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg    <= rlc_action_t'(req.action);
            key_reg    <= req.key_id;
            frame_reg  <= req.frame_number;
            bytes_reg  <= req.entry_bytes;
            handle_reg <= req.slot_handle;
        end
        evict_reg   <= evict_next;
        fslot_reg   <= fslot_next;
        hold_reg    <= hold_next;
        free_reg    <= free_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        rslot_reg   <= rslot_next;
        if (state_reg == S_FINISH && (!rsp_valid_reg || rsp.ready))
        begin
            rsp.status        <= status_reg;
            rsp.hit           <= hit_reg;
            rsp.slot_out      <= rslot_reg;
            rsp.total_bytes   <= total_reg;
            rsp.entries_used  <= 7'(used_reg);
            rsp.evicted_count <= 7'(evict_reg);
        end
    end

    assign rsp.valid = rsp_valid_reg;

    `RLC_ASSERT_IMPL(a_used_bound, 1'b1, used_reg <= UW'(ENTRIES), "used count over capacity")
    `RLC_ASSERT_IMPL(a_map_count, state_reg == S_IDLE, UW'($countones(smap_reg)) == used_reg, "slot map and used count disagree")
    `RLC_ASSERT_NEXT(a_walk_step, state_reg == S_WALK && cnt_reg != LAST, state_reg == S_WALK && cnt_reg == $past(cnt_reg) + SW'(1), "walk counter skipped")
    `RLC_ASSERT_NEXT(a_finish_hold, state_reg == S_FINISH && rsp_valid_reg && !rsp.ready, state_reg == S_FINISH, "result lost under stall")
endmodule
